### rtl/rsc_pkg.sv
package rsc_pkg;

    // Default data memory depth in words
    localparam int DATA_WORDS_DEF = 1024;

    localparam int XLEN = 32;
    localparam int REG_IDX_W = 5;
    localparam int REG_COUNT = 32;

    // Primary opcode field, instruction bits 31:26
    typedef enum logic [5:0] {
        OP_SPECIAL = 6'h00,
        OP_J       = 6'h02,
        OP_BEQ     = 6'h04,
        OP_BNE     = 6'h05,
        OP_ADDI    = 6'h08,
        OP_LW      = 6'h23,
        OP_SW      = 6'h2B
    } opcode_t;

    // Function field of the register-register group, bits 5:0
    typedef enum logic [5:0] {
        FN_SLLV = 6'h04,
        FN_SRLV = 6'h06,
        FN_JR   = 6'h08,
        FN_ADD  = 6'h20,
        FN_SUB  = 6'h22,
        FN_AND  = 6'h24,
        FN_OR   = 6'h25,
        FN_XOR  = 6'h26,
        FN_NOR  = 6'h27,
        FN_SLT  = 6'h2A
    } funct_t;

    localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;

endpackage

### rtl/risc_single_cycle_core.sv
// Integer core for a 32-bit load/store instruction subset (ADD, SUB, AND, OR, XOR, NOR,
// SLT, SLLV, SRLV, JR, ADDI, LW, SW, BEQ, BNE, J) without a delay slot. Each transfer on
// s_ carries one instruction word fetched at the address last reported on m_next_pc
// (0 after reset); each transfer on m_ reports the next fetch address and the register
// write, store and branch effects of that instruction. One instruction is taken per
// clock while neither m_ready back-pressure nor the memory clear holds s_ready low: an
// execute register and a result register form a two-stage pipe, with the result of the
// older instruction forwarded into the younger one; the result register drives m_valid.
// The register file is read for both operands on the s_ transfer into the execute
// register; the data memory reads one word per execute advance at one port with
// registered read data. After reset the data memory is swept to zero, one word per
// cycle, so s_ready stays low until the sweep ends. DATA_WORDS must be a power of two;
// the word index is address bits [log2(DATA_WORDS)+1:2], higher address bits alias.
module risc_single_cycle_core
    import rsc_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_reg_write,
    output logic [4:0]  m_reg_index,
    output logic [31:0] m_reg_value,
    output logic        m_store_done,
    output logic [31:0] m_mem_address,
    output logic [31:0] m_store_value,
    output logic        m_branch_taken
);

    localparam int IDX_W = $clog2(DATA_WORDS);

    // Storage
    logic [XLEN-1:0]      rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [XLEN-1:0]      dmem [DATA_WORDS];
    logic [XLEN-1:0]      dmem_rdata_reg;

    // Clear sweep
    logic             clearing_reg, clearing_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;

    // Execute stage
    logic            e_valid_reg, e_valid_next;
    logic            e_dep_reg, e_dep_next;
    logic [31:0]     e_instr_reg;
    logic [XLEN-1:0] e_a_reg;
    logic [XLEN-1:0] e_b_reg;
    logic [31:0]     pc_reg, pc_next;

    // Result stage
    logic            w_valid_reg, w_valid_next;
    logic            w_new_reg, w_new_next;
    logic [31:0]     w_next_pc_reg;
    logic            w_reg_write_reg;
    logic [4:0]      w_reg_index_reg;
    logic [XLEN-1:0] w_alu_reg;
    logic            w_is_load_reg;
    logic            w_store_done_reg;
    logic [31:0]     w_mem_address_reg;
    logic [31:0]     w_store_value_reg;
    logic            w_branch_taken_reg;

    logic            s_accept;
    logic            e_adv;
    logic [XLEN-1:0] w_value;

    // Decode fields
    logic [5:0]       opc;
    logic [5:0]       fn;
    logic [4:0]       rs_idx, rt_idx, rd_idx;
    logic [4:0]       in_rs, in_rt;
    logic [31:0]      sext;
    logic [XLEN-1:0]  op_a, op_b;
    logic [31:0]      seq_pc;
    logic [31:0]      ex_next_pc;
    logic             ex_write, ex_load, ex_store, ex_taken;
    logic [4:0]       ex_index;
    logic [XLEN-1:0]  ex_value;
    logic [31:0]      ex_maddr;
    logic [31:0]      ex_addr_sum;
    logic [IDX_W-1:0] ex_slot;

    assign e_adv    = e_valid_reg && (!w_valid_reg || m_ready);
    assign s_ready  = !clearing_reg && (!e_valid_reg || e_adv);
    assign s_accept = s_valid && s_ready;
    assign w_value  = w_is_load_reg ? dmem_rdata_reg : w_alu_reg;

    assign opc    = e_instr_reg[31:26];
    assign rs_idx = e_instr_reg[25:21];
    assign rt_idx = e_instr_reg[20:16];
    assign rd_idx = e_instr_reg[15:11];
    assign fn     = e_instr_reg[5:0];
    assign sext   = {{16{e_instr_reg[15]}}, e_instr_reg[15:0]};
    assign in_rs  = s_instruction[25:21];
    assign in_rt  = s_instruction[20:16];

    // Forward the older instruction's result when it was not yet in the file at read time
    always_comb begin
        op_a = e_a_reg;
        op_b = e_b_reg;
        if (e_dep_reg && w_reg_write_reg && (w_reg_index_reg != 5'd0)) begin
            if (w_reg_index_reg == rs_idx) begin
                op_a = w_value;
            end
            if (w_reg_index_reg == rt_idx) begin
                op_b = w_value;
            end
        end
    end

    // Execute one instruction
    always_comb begin
        seq_pc      = pc_reg + 32'd4;
        ex_addr_sum = op_a + sext;
        ex_next_pc  = seq_pc;
        ex_write    = 1'b0;
        ex_load     = 1'b0;
        ex_store    = 1'b0;
        ex_taken    = 1'b0;
        ex_index    = 5'd0;
        ex_value    = '0;
        ex_maddr    = '0;
        case (opc)
            OP_SPECIAL: begin
                ex_write = 1'b1;
                ex_index = rd_idx;
                case (fn)
                    FN_ADD:  ex_value = op_a + op_b;
                    FN_SUB:  ex_value = op_a - op_b;
                    FN_AND:  ex_value = op_a & op_b;
                    FN_OR:   ex_value = op_a | op_b;
                    FN_XOR:  ex_value = op_a ^ op_b;
                    FN_NOR:  ex_value = ~(op_a | op_b);
                    FN_SLT:  ex_value = {31'd0, $signed(op_a) < $signed(op_b)};
                    FN_SLLV: ex_value = op_b << op_a[4:0];
                    FN_SRLV: ex_value = op_b >> op_a[4:0];
                    FN_JR: begin
                        ex_write   = 1'b0;
                        ex_index   = 5'd0;
                        ex_next_pc = op_a;
                        ex_taken   = 1'b1;
                    end
                    default: begin
                        ex_write = 1'b0;
                        ex_index = 5'd0;
                    end
                endcase
            end
            OP_ADDI: begin
                ex_write = 1'b1;
                ex_index = rt_idx;
                ex_value = ex_addr_sum;
            end
            OP_LW: begin
                ex_write = 1'b1;
                ex_load  = 1'b1;
                ex_index = rt_idx;
                ex_maddr = ex_addr_sum;
            end
            OP_SW: begin
                ex_store = 1'b1;
                ex_maddr = ex_addr_sum;
            end
            OP_BEQ, OP_BNE: begin
                if ((op_a == op_b) == (opc == OP_BEQ)) begin
                    ex_next_pc = seq_pc + {sext[29:0], 2'b00};
                    ex_taken   = 1'b1;
                end
            end
            OP_J: begin
                ex_next_pc = (seq_pc & JUMP_REGION_MASK) | {4'd0, e_instr_reg[25:0], 2'b00};
                ex_taken   = 1'b1;
            end
            default: begin
                ex_write = 1'b0;
            end
        endcase
        ex_slot = ex_addr_sum[IDX_W+1:2];
    end

    // Control next state
    always_comb begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg) begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(DATA_WORDS - 1)) begin
                clearing_next = 1'b0;
            end
        end

        e_valid_next = e_valid_reg;
        e_dep_next   = e_dep_reg;
        if (s_accept) begin
            e_valid_next = 1'b1;
            e_dep_next   = e_adv;
        end else begin
            if (e_adv) begin
                e_valid_next = 1'b0;
            end
            e_dep_next = 1'b0;
        end

        w_valid_next = w_valid_reg;
        if (e_adv) begin
            w_valid_next = 1'b1;
        end else if (m_ready) begin
            w_valid_next = 1'b0;
        end
        w_new_next = e_adv;

        pc_next = e_adv ? ex_next_pc : pc_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            e_valid_reg  <= 1'b0;
            e_dep_reg    <= 1'b0;
            w_valid_reg  <= 1'b0;
            w_new_reg    <= 1'b0;
            pc_reg       <= '0;
            rf_valid_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
            e_valid_reg  <= e_valid_next;
            e_dep_reg    <= e_dep_next;
            w_valid_reg  <= w_valid_next;
            w_new_reg    <= w_new_next;
            pc_reg       <= pc_next;
            if (w_new_reg && w_reg_write_reg && (w_reg_index_reg != 5'd0)) begin
                rf_valid_reg[w_reg_index_reg] <= 1'b1;
            end
        end
    end

    // Register file: write back the result in the cycle after it lands, read on transfer
    always_ff @(posedge aclk) begin
        if (w_new_reg && w_reg_write_reg && (w_reg_index_reg != 5'd0)) begin
            rf_mem[w_reg_index_reg] <= w_value;
        end
        if (s_accept) begin
            e_instr_reg <= s_instruction;
            if (in_rs == 5'd0) begin
                e_a_reg <= '0;
            end else if (w_new_reg && w_reg_write_reg && (w_reg_index_reg == in_rs)) begin
                e_a_reg <= w_value;
            end else begin
                e_a_reg <= rf_valid_reg[in_rs] ? rf_mem[in_rs] : '0;
            end
            if (in_rt == 5'd0) begin
                e_b_reg <= '0;
            end else if (w_new_reg && w_reg_write_reg && (w_reg_index_reg == in_rt)) begin
                e_b_reg <= w_value;
            end else begin
                e_b_reg <= rf_valid_reg[in_rt] ? rf_mem[in_rt] : '0;
            end
        end else if (e_dep_reg) begin
            // Hold: latch the forwarded operands while the older result is still here
            e_a_reg <= op_a;
            e_b_reg <= op_b;
        end
    end

    // Data memory: clear sweep after reset, then stores and load reads
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            dmem[clr_idx_reg] <= '0;
        end else if (e_adv && ex_store) begin
            dmem[ex_slot] <= op_b;
        end
        if (e_adv) begin
            dmem_rdata_reg <= dmem[ex_slot];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (e_adv) begin
            w_next_pc_reg      <= ex_next_pc;
            w_reg_write_reg    <= ex_write;
            w_reg_index_reg    <= ex_index;
            w_alu_reg          <= ex_value;
            w_is_load_reg      <= ex_load;
            w_store_done_reg   <= ex_store;
            w_mem_address_reg  <= ex_maddr;
            w_store_value_reg  <= ex_store ? op_b : '0;
            w_branch_taken_reg <= ex_taken;
        end
    end

    assign m_valid        = w_valid_reg;
    assign m_next_pc      = w_next_pc_reg;
    assign m_reg_write    = w_reg_write_reg;
    assign m_reg_index    = w_reg_index_reg;
    assign m_reg_value    = w_value;
    assign m_store_done   = w_store_done_reg;
    assign m_mem_address  = w_mem_address_reg;
    assign m_store_value  = w_store_value_reg;
    assign m_branch_taken = w_branch_taken_reg;

    // Checks
    a_no_transfer_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready)
        else $error("input taken during memory clear");

    a_store_not_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_reg_write && m_store_done))
        else $error("store and register write in one result");

    a_fwd_pairs_with_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        e_dep_reg |-> (w_new_reg && w_valid_reg))
        else $error("forwarding without a fresh result");

    a_no_write_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_reg_write) |-> (m_reg_value == '0 && m_reg_index == 5'd0))
        else $error("stale write fields on a result without write");

endmodule

### sim/risc_core_checker.sv
module risc_core_checker
    import rsc_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_instruction,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_next_pc,
    input  logic        m_reg_write,
    input  logic [4:0]  m_reg_index,
    input  logic [31:0] m_reg_value,
    input  logic        m_store_done,
    input  logic [31:0] m_mem_address,
    input  logic [31:0] m_store_value,
    input  logic        m_branch_taken,
    output int          fail_count,
    output int          pending_count
);

    localparam int MEM_AW = $clog2(DATA_WORDS);

    // Architectural effects of one retired instruction
    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        store_done;
        logic [31:0] mem_address;
        logic [31:0] store_value;
        logic        branch_taken;
    } retire_t;

    logic [31:0] arch_pc;
    logic [31:0] gpr [REG_COUNT];
    logic [31:0] data_mem [DATA_WORDS];
    retire_t     retire_q [$];
    int          n_bad = 0;

    // Execute one instruction against the shadow state and return its effects
    function automatic retire_t execute_instr(input logic [31:0] ins);
        retire_t     r;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] seq;
        rs  = ins[25:21];
        rt  = ins[20:16];
        a   = (rs == 5'd0) ? 32'd0 : gpr[rs];
        b   = (rt == 5'd0) ? 32'd0 : gpr[rt];
        imm = {{16{ins[15]}}, ins[15:0]};
        seq = arch_pc + 32'd4;
        r   = '0;
        r.next_pc = seq;
        case (ins[31:26])
            OP_SPECIAL: begin
                r.reg_write = 1'b1;
                r.reg_index = ins[15:11];
                case (ins[5:0])
                    FN_ADD:  r.reg_value = a + b;
                    FN_SUB:  r.reg_value = a - b;
                    FN_AND:  r.reg_value = a & b;
                    FN_OR:   r.reg_value = a | b;
                    FN_XOR:  r.reg_value = a ^ b;
                    FN_NOR:  r.reg_value = ~(a | b);
                    FN_SLT:  r.reg_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    FN_SLLV: r.reg_value = b << a[4:0];
                    FN_SRLV: r.reg_value = b >> a[4:0];
                    FN_JR: begin
                        r.reg_write    = 1'b0;
                        r.next_pc      = a;
                        r.branch_taken = 1'b1;
                    end
                    default: r.reg_write = 1'b0;
                endcase
            end
            OP_ADDI: begin
                r.reg_write = 1'b1;
                r.reg_index = rt;
                r.reg_value = a + imm;
            end
            OP_LW: begin
                r.mem_address = a + imm;
                r.reg_write   = 1'b1;
                r.reg_index   = rt;
                r.reg_value   = data_mem[r.mem_address[MEM_AW+1:2]];
            end
            OP_SW: begin
                r.mem_address = a + imm;
                r.store_done  = 1'b1;
                r.store_value = b;
                data_mem[r.mem_address[MEM_AW+1:2]] = b;
            end
            OP_BEQ, OP_BNE: begin
                if ((a == b) == (ins[31:26] == OP_BEQ)) begin
                    r.next_pc      = seq + (imm << 2);
                    r.branch_taken = 1'b1;
                end
            end
            OP_J: begin
                r.next_pc      = (seq & JUMP_REGION_MASK) | {4'd0, ins[25:0], 2'b00};
                r.branch_taken = 1'b1;
            end
            default: ;
        endcase
        // Report r0 writes but keep r0 at zero
        if (!r.reg_write) begin
            r.reg_index = '0;
            r.reg_value = '0;
        end else if (r.reg_index != 5'd0) begin
            gpr[r.reg_index] = r.reg_value;
        end
        arch_pc = r.next_pc;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
            n_bad++;
        end
    endtask

    always @(posedge aclk) begin
        retire_t want;
        if (!aresetn) begin
            arch_pc = '0;
            foreach (gpr[i]) gpr[i] = '0;
            foreach (data_mem[i]) data_mem[i] = '0;
            retire_q.delete();
        end else begin
            // Compare each result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                if (retire_q.size() == 0) begin
                    $display("%0t: unexpected result transfer: expected none, actual next_pc %h",
                             $time, m_next_pc);
                    n_bad++;
                end else begin
                    want = retire_q.pop_front();
                    check_field("next_pc", want.next_pc, m_next_pc);
                    check_field("reg_write", 32'(want.reg_write), 32'(m_reg_write));
                    check_field("reg_index", 32'(want.reg_index), 32'(m_reg_index));
                    check_field("reg_value", want.reg_value, m_reg_value);
                    check_field("store_done", 32'(want.store_done), 32'(m_store_done));
                    check_field("mem_address", want.mem_address, m_mem_address);
                    check_field("store_value", want.store_value, m_store_value);
                    check_field("branch_taken", 32'(want.branch_taken),
                                32'(m_branch_taken));
                end
            end
            // Predict each accepted instruction
            if (s_valid && s_ready) begin
                retire_q.push_back(execute_instr(s_instruction));
            end
        end
        fail_count    <= n_bad;
        pending_count <= retire_q.size();
    end

endmodule

### sim/tb_risc_single_cycle_core.sv
module tb_risc_single_cycle_core
    import rsc_pkg::*;
();

    localparam int N_ITEMS = 1000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_instruction = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_next_pc;
    logic        m_reg_write;
    logic [4:0]  m_reg_index;
    logic [31:0] m_reg_value;
    logic        m_store_done;
    logic [31:0] m_mem_address;
    logic [31:0] m_store_value;
    logic        m_branch_taken;
    int          fail_count;
    int          pending_count;
    int          n_sent = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    risc_single_cycle_core #(
        .DATA_WORDS(DATA_WORDS_DEF)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_instruction (s_instruction),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_pc     (m_next_pc),
        .m_reg_write   (m_reg_write),
        .m_reg_index   (m_reg_index),
        .m_reg_value   (m_reg_value),
        .m_store_done  (m_store_done),
        .m_mem_address (m_mem_address),
        .m_store_value (m_store_value),
        .m_branch_taken(m_branch_taken)
    );

    risc_core_checker #(
        .DATA_WORDS(DATA_WORDS_DEF)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_instruction (s_instruction),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_pc     (m_next_pc),
        .m_reg_write   (m_reg_write),
        .m_reg_index   (m_reg_index),
        .m_reg_value   (m_reg_value),
        .m_store_done  (m_store_done),
        .m_mem_address (m_mem_address),
        .m_store_value (m_store_value),
        .m_branch_taken(m_branch_taken),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic logic [31:0] enc_r(input funct_t fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sh);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input opcode_t op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [25:0] tgt);
        return {OP_J, tgt};
    endfunction

    // Favor a few low registers so results feed later instructions
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    // Draw a mostly well-formed instruction with random operands
    function automatic logic [31:0] rand_instr();
        int          sel;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [5:0]  slot;
        logic [15:0] mem_imm;
        logic [31:0] w;
        funct_t      fn;
        sel  = $urandom_range(0, 99);
        rs   = pick_reg();
        rt   = pick_reg();
        rd   = pick_reg();
        slot = {4'($urandom_range(0, 15)),
                ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b00};
        // Keep most accesses in a small window, some aliased or below zero
        case ($urandom_range(0, 5))
            0:       mem_imm = 16'(DATA_WORDS_DEF * 4) + {10'd0, slot};
            1:       mem_imm = 16'd0 - {10'd0, slot} - 16'd4;
            default: mem_imm = {10'd0, slot};
        endcase
        case ($urandom_range(0, 8))
            0:       fn = FN_ADD;
            1:       fn = FN_SUB;
            2:       fn = FN_AND;
            3:       fn = FN_OR;
            4:       fn = FN_XOR;
            5:       fn = FN_NOR;
            6:       fn = FN_SLT;
            7:       fn = FN_SLLV;
            default: fn = FN_SRLV;
        endcase
        if (sel < 30) begin
            w = enc_r(fn, rs, rt, rd, 5'($urandom));
        end else if (sel < 45) begin
            w = enc_i(OP_ADDI, rs, rd,
                      $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 31)));
        end else if (sel < 57) begin
            w = enc_i(OP_LW, ($urandom_range(0, 9) < 6) ? 5'd0 : rs, rd, mem_imm);
        end else if (sel < 69) begin
            w = enc_i(OP_SW, ($urandom_range(0, 9) < 6) ? 5'd0 : rs, rt, mem_imm);
        end else if (sel < 79) begin
            if ($urandom_range(0, 2) == 0) begin
                rt = rs;
            end
            w = enc_i((sel < 74) ? OP_BEQ : OP_BNE, rs, rt, 16'($urandom));
        end else if (sel < 83) begin
            w = enc_j(26'($urandom));
        end else if (sel < 87) begin
            w = enc_r(FN_JR, rs, 5'($urandom), 5'($urandom), 5'($urandom));
        end else if (sel < 91) begin
            w = {OP_SPECIAL, 20'($urandom), 6'($urandom)};
        end else begin
            w = $urandom;
        end
        return w;
    endfunction

    // Offer one instruction and hold it until the transfer
    task automatic push_instr(input logic [31:0] w);
        s_valid       <= 1'b1;
        s_instruction <= w;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    initial begin
        int burst;
        int gap;
        int guard;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, every operation, wrap and aliasing cases
        push_instr(enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7fff));
        push_instr(enc_i(OP_ADDI, 5'd0, 5'd2, 16'hffff));
        push_instr(enc_i(OP_ADDI, 5'd2, 5'd3, 16'h8000));
        push_instr(enc_r(FN_ADD, 5'd2, 5'd2, 5'd4, 5'd31));
        push_instr(enc_r(FN_SUB, 5'd0, 5'd2, 5'd5, 5'd0));
        push_instr(enc_r(FN_AND, 5'd1, 5'd2, 5'd6, 5'd0));
        push_instr(enc_r(FN_OR, 5'd3, 5'd1, 5'd7, 5'd0));
        push_instr(enc_r(FN_XOR, 5'd2, 5'd1, 5'd8, 5'd0));
        push_instr(enc_r(FN_NOR, 5'd0, 5'd0, 5'd9, 5'd0));
        push_instr(enc_r(FN_SLT, 5'd2, 5'd1, 5'd10, 5'd0));
        push_instr(enc_r(FN_SLT, 5'd1, 5'd2, 5'd11, 5'd0));
        push_instr(enc_r(FN_SLLV, 5'd1, 5'd2, 5'd12, 5'd0));
        push_instr(enc_r(FN_SRLV, 5'd1, 5'd12, 5'd13, 5'd0));
        push_instr(enc_i(OP_ADDI, 5'd1, 5'd0, 16'd5));
        push_instr(enc_r(FN_ADD, 5'd0, 5'd1, 5'd14, 5'd0));
        push_instr(enc_i(OP_SW, 5'd0, 5'd2, 16'h0000));
        push_instr(enc_i(OP_SW, 5'd0, 5'd1, 16'(DATA_WORDS_DEF * 4)));
        push_instr(enc_i(OP_LW, 5'd0, 5'd15, 16'h0003));
        push_instr(enc_i(OP_SW, 5'd0, 5'd12, 16'hfffc));
        push_instr(enc_i(OP_LW, 5'd0, 5'd16, 16'(DATA_WORDS_DEF * 4 - 4)));
        push_instr(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hffff));
        push_instr(enc_i(OP_BNE, 5'd0, 5'd0, 16'h1234));
        push_instr(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7fff));
        push_instr(enc_j(26'h3ffffff));
        push_instr(enc_r(FN_JR, 5'd2, 5'd0, 5'd0, 5'd0));
        push_instr(32'hffff_ffff);
        push_instr(32'h0000_0000);

        // Random bursts with random gaps, some runs without any gap
        while (n_sent < N_ITEMS) begin
            burst = $urandom_range(1, 20);
            repeat (burst) push_instr(rand_instr());
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results once the count covers the last transfer
        @(posedge aclk);
        guard = 0;
        while (pending_count != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("** risc_single_cycle_core: PASSED **");
        end else begin
            $display("** risc_single_cycle_core: FAILED **");
        end
        $finish;
    end

    // Receiver: switch among random stall patterns, hold off twice to back up the pipe
    initial begin
        int  cyc;
        int  mode;
        int  hold_left;
        int  holds_done;
        bit  rdy;
        cyc        = 0;
        mode       = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (cyc % 50 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (hold_left == 0 && holds_done < 2 && n_sent >= 300 + holds_done * 400) begin
                hold_left = 80;
                holds_done++;
            end
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = (cyc % 7 == 0);
                endcase
            end
            m_ready <= rdy;
            cyc++;
        end
    end

    // Watchdog
    initial begin
        #3000000;
        $display("** risc_single_cycle_core: FAILED **");
        $finish;
    end

endmodule
